// ===== src/pdb_pkg.sv =====
// Package for the point projection depth buffer.
// Shared types, codes and the subsample reciprocal table; no dependencies.
package pdb_pkg;

  localparam int GW   = 11;  // grid coordinate width, holds up to 2047
  localparam int NW   = 14;  // sensor index width
  localparam int IDXW = 20;  // pixel address width carried through the queue
  localparam int RK   = 18;  // reciprocal scale shift
  localparam int MW   = 19;  // reciprocal width

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [3:0] ST_STORED   = 4'd0;
  localparam logic [3:0] ST_NONFIN   = 4'd1;
  localparam logic [3:0] ST_RANGE    = 4'd2;
  localparam logic [3:0] ST_GROUND   = 4'd3;
  localparam logic [3:0] ST_BEHIND   = 4'd4;
  localparam logic [3:0] ST_OFFGRID  = 4'd5;
  localparam logic [3:0] ST_FARTHER  = 4'd6;
  localparam logic [3:0] ST_READ     = 4'd7;
  localparam logic [3:0] ST_CLEARED  = 4'd8;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_RMIN   = 3'd1;
  localparam logic [2:0] CFG_RMAX   = 3'd2;
  localparam logic [2:0] CFG_NORMAL = 3'd3;
  localparam logic [2:0] CFG_OFFSET = 3'd4;
  localparam logic [2:0] CFG_FLOOR  = 3'd5;
  localparam logic [2:0] CFG_SUBS   = 3'd6;

  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_INSERT = 2'd1,
    K_READ   = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        rmin;
    logic [15:0]        rmax;
    logic [47:0]        normal;
    logic signed [15:0] offset;
    logic signed [15:0] floor_mm;
    logic [3:0]         ds;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        status;
    logic [IDXW-1:0]   addr;
    logic [47:0]       point;
    logic [31:0]       rsq;
  } work_t;

  // ceil(2^RK / ds); exact floor division for 14-bit numerators
  function automatic logic [MW-1:0] recip(input logic [3:0] ds);
    logic [MW-1:0] m;
    case (ds)
      4'd2:    m = 19'd131072;
      4'd3:    m = 19'd87382;
      4'd4:    m = 19'd65536;
      4'd5:    m = 19'd52429;
      4'd6:    m = 19'd43691;
      4'd7:    m = 19'd37450;
      4'd8:    m = 19'd32768;
      4'd9:    m = 19'd29128;
      4'd10:   m = 19'd26215;
      4'd11:   m = 19'd23832;
      4'd12:   m = 19'd21846;
      4'd13:   m = 19'd20165;
      4'd14:   m = 19'd18725;
      4'd15:   m = 19'd17477;
      default: m = 19'd262144;
    endcase
    return m;
  endfunction

endpackage

// ===== src/pdb_in_if.sv =====
// Input channel of the depth buffer: valid/ready plus one command item.
// Standalone; no package dependency.
interface pdb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [13:0]        point_index;
  logic               point_finite;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [6:0]         pixel_u;
  logic [6:0]         pixel_v;

  modport source (output valid, func, point_index, point_finite, coord_x, coord_y,
                  coord_z, pixel_u, pixel_v, input ready);
  modport sink (input valid, func, point_index, point_finite, coord_x, coord_y,
                coord_z, pixel_u, pixel_v, output ready);
endinterface

// ===== src/pdb_out_if.sv =====
// Result channel of the depth buffer: valid/ready plus one result item.
// Standalone; no package dependency.
interface pdb_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic               pixel_valid;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic [15:0]        range_mm;

  modport source (output valid, status, pixel_valid, out_x, out_y, out_z, range_mm,
                  input ready);
  modport sink (input valid, status, pixel_valid, out_x, out_y, out_z, range_mm,
                output ready);
endinterface

// ===== src/pdb_front.sv =====
// Front end: accepts items, runs range/ground/grid checks and pixel mapping.
// Depends on pdb_pkg and pdb_in_if; pushes classified work to pdb_queue.
module pdb_front #(
  parameter int SENSOR_COLS = 128,
  parameter int SENSOR_ROWS = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  pdb_in_if.sink         in_ch,
  input  pdb_pkg::cfg_t  cfg,
  input  logic           init_busy,
  input  logic           q_full,
  output logic           push,
  output pdb_pkg::work_t work
);
  import pdb_pkg::*;

  localparam int DEPTH = SENSOR_COLS * SENSOR_ROWS;
  localparam logic [NW-1:0] CM1 = NW'(SENSOR_COLS - 1);
  localparam logic [NW-1:0] RM1 = NW'(SENSOR_ROWS - 1);

  logic               busy_r;
  logic [1:0]         ph_r;
  logic [1:0]         func_r;
  logic [NW-1:0]      idx_r;
  logic               fin_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic [6:0]         pu_r, pv_r;
  logic signed [31:0] xx_r, yy_r, zz_r, gx_r, gy_r, gz_r;
  logic [31:0]        mn_r, mx_r, rsq_r;
  logic [NW-1:0]      nu_r, nv_r;
  logic signed [35:0] hgt_r;
  logic [NW:0]        qu_r, qv_r;
  logic [GW-1:0]      w_r, h_r, u_r, v_r;
  logic [3:0]         st_r;
  kind_t              kind_r;

  logic [MW-1:0]      m;
  logic [NW+MW-1:0]   pu_prod, pv_prod, pw_prod, ph_prod;
  logic signed [35:0] off36, fl36;
  logic [2*GW-1:0]    pix;
  logic               pix_bad;
  kind_t              kind_fin;
  logic [3:0]         st_fin;

  assign in_ch.ready = !busy_r && !init_busy;

  always_comb begin
    m       = recip(cfg.ds);
    pu_prod = nu_r * m;
    pv_prod = nv_r * m;
    pw_prod = CM1 * m;
    ph_prod = RM1 * m;
    off36   = 36'(cfg.offset) <<< 14;
    fl36    = 36'(cfg.floor_mm) <<< 14;
    pix     = v_r * w_r + (2*GW)'(u_r);
    pix_bad = pix >= (2*GW)'(DEPTH);
    kind_fin = kind_r;
    st_fin   = st_r;
    if (pix_bad && kind_r == K_INSERT) begin
      kind_fin = K_DIRECT;
      st_fin   = ST_OFFGRID;
    end else if (pix_bad && kind_r == K_READ) begin
      kind_fin = K_DIRECT;
    end
  end

  assign push        = busy_r && ph_r == 2'd3 && !q_full;
  assign work.kind   = kind_fin;
  assign work.status = st_fin;
  assign work.addr   = IDXW'(pix);
  assign work.point  = {z_r, y_r, x_r};
  assign work.rsq    = rsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
    end else if (in_ch.valid && in_ch.ready) begin
      busy_r <= 1'b1;
      ph_r   <= 2'd0;
    end else if (busy_r && ph_r != 2'd3) begin
      ph_r <= ph_r + 2'd1;
    end else if (push) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      idx_r  <= in_ch.point_index;
      fin_r  <= in_ch.point_finite;
      x_r    <= in_ch.coord_x;
      y_r    <= in_ch.coord_y;
      z_r    <= in_ch.coord_z;
      pu_r   <= in_ch.pixel_u;
      pv_r   <= in_ch.pixel_v;
    end
    if (busy_r && ph_r == 2'd0) begin
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      zz_r <= z_r * z_r;
      gx_r <= signed'(cfg.normal[15:0]) * x_r;
      gy_r <= signed'(cfg.normal[31:16]) * y_r;
      gz_r <= signed'(cfg.normal[47:32]) * z_r;
      mn_r <= cfg.rmin * cfg.rmin;
      mx_r <= cfg.rmax * cfg.rmax;
      if (cfg.mode[1]) begin
        nu_r <= NW'(idx_r / SENSOR_ROWS);
        nv_r <= NW'(idx_r % SENSOR_ROWS);
      end else begin
        nu_r <= NW'(idx_r % SENSOR_COLS);
        nv_r <= NW'(idx_r / SENSOR_COLS);
      end
    end
    if (busy_r && ph_r == 2'd1) begin
      rsq_r <= 32'(xx_r) + 32'(yy_r) + 32'(zz_r);
      hgt_r <= 36'(gx_r) + 36'(gy_r) + 36'(gz_r) + off36;
      qu_r  <= pu_prod[NW+MW-1:RK];
      qv_r  <= pv_prod[NW+MW-1:RK];
      w_r   <= GW'(pw_prod[NW+MW-1:RK]) + GW'(1);
      h_r   <= GW'(ph_prod[NW+MW-1:RK]) + GW'(1);
    end
    if (busy_r && ph_r == 2'd2) begin
      kind_r <= K_DIRECT;
      u_r    <= '0;
      v_r    <= '0;
      if (func_r == FN_INSERT) begin
        if (!fin_r) begin
          st_r <= ST_NONFIN;
        end else if (rsq_r < mn_r || rsq_r > mx_r) begin
          st_r <= ST_RANGE;
        end else if (cfg.mode[0] && hgt_r < fl36) begin
          st_r <= ST_GROUND;
        end else if (z_r <= 16'sd0) begin
          st_r <= ST_BEHIND;
        end else if (qu_r >= (NW+1)'(w_r) || qv_r >= (NW+1)'(h_r)) begin
          st_r <= ST_OFFGRID;
        end else begin
          st_r   <= ST_STORED;
          kind_r <= K_INSERT;
          if (cfg.mode[1]) begin
            u_r <= GW'(qu_r);
            v_r <= GW'(qv_r);
          end else begin
            u_r <= w_r - GW'(1) - GW'(qu_r);
            v_r <= h_r - GW'(1) - GW'(qv_r);
          end
        end
      end else if (func_r == FN_CLEAR) begin
        st_r   <= ST_CLEARED;
        kind_r <= K_CLEAR;
      end else begin
        st_r <= ST_READ;
        if (GW'(pu_r) < w_r && GW'(pv_r) < h_r) begin
          kind_r <= K_READ;
          u_r    <= GW'(pu_r);
          v_r    <= GW'(pv_r);
        end
      end
    end
  end

endmodule

// ===== src/pdb_queue.sv =====
// Two-entry work queue between the front end and the pixel store back end.
// Depends on pdb_pkg.
module pdb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pdb_pkg::work_t push_data,
  input  logic           pop,
  output pdb_pkg::work_t head,
  output logic           full,
  output logic           empty
);
  import pdb_pkg::*;

  work_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head  = ent_r[rp_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule

// ===== src/pdb_back.sv =====
// Back end: pixel store memories, closest-point update, range square root,
// mark clearing sweep and the result register. Depends on pdb_pkg, pdb_out_if.
module pdb_back #(
  parameter int SENSOR_COLS = 128,
  parameter int SENSOR_ROWS = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pdb_pkg::work_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           init_busy,
  pdb_out_if.source      out_ch
);
  import pdb_pkg::*;

  localparam int DEPTH = SENSOR_COLS * SENSOR_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_LOOK = 5'b00010,
    B_SQRT = 5'b00100,
    B_CLR  = 5'b01000,
    B_EMIT = 5'b10000
  } bstate_t;

  logic        mark_mem [DEPTH];
  logic [47:0] pt_mem   [DEPTH];
  logic [31:0] rs_mem   [DEPTH];

  bstate_t       st_r, st_nxt;
  work_t         cur_r;
  logic [AW-1:0] cnt_r;
  logic          init_r;
  logic [31:0]   sq_n_r, sq_res_r, sq_bit_r;
  logic          mk_q;
  logic [47:0]   pt_q;
  logic [31:0]   rs_q;

  logic          ov_r, opv_r;
  logic [3:0]    ost_r;
  logic [47:0]   opt_r;
  logic [15:0]   orng_r;

  logic          out_free, emit, e_pv, rd_en, mark_we, mark_wd, data_we, sq_load;
  logic [3:0]    e_st;
  logic [47:0]   e_pt;
  logic [15:0]   e_rng;
  logic [AW-1:0] wr_addr;
  logic [31:0]   sq_sum;

  assign out_free  = !ov_r || out_ch.ready;
  assign init_busy = init_r;
  assign wr_addr   = (st_r == B_CLR) ? cnt_r : cur_r.addr[AW-1:0];
  assign sq_sum    = sq_res_r + sq_bit_r;

  always_comb begin
    st_nxt  = st_r;
    pop     = 1'b0;
    emit    = 1'b0;
    e_st    = ST_READ;
    e_pv    = 1'b0;
    e_pt    = '0;
    e_rng   = '0;
    rd_en   = 1'b0;
    mark_we = 1'b0;
    mark_wd = 1'b0;
    data_we = 1'b0;
    sq_load = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            K_DIRECT: begin
              if (out_free) begin
                pop  = 1'b1;
                emit = 1'b1;
                e_st = head.status;
              end
            end
            K_CLEAR: begin
              pop    = 1'b1;
              st_nxt = B_CLR;
            end
            default: begin
              pop    = 1'b1;
              rd_en  = 1'b1;
              st_nxt = B_LOOK;
            end
          endcase
        end
      end
      B_LOOK: begin
        if (cur_r.kind == K_INSERT) begin
          if (out_free) begin
            emit   = 1'b1;
            st_nxt = B_IDLE;
            if (mk_q && cur_r.rsq >= rs_q) begin
              e_st = ST_FARTHER;
            end else begin
              e_st    = ST_STORED;
              mark_we = 1'b1;
              mark_wd = 1'b1;
              data_we = 1'b1;
            end
          end
        end else if (mk_q) begin
          sq_load = 1'b1;
          st_nxt  = B_SQRT;
        end else if (out_free) begin
          emit   = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      B_SQRT: begin
        if (sq_bit_r == 32'd0) st_nxt = B_EMIT;
      end
      B_CLR: begin
        mark_we = 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) st_nxt = init_r ? B_IDLE : B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          emit   = 1'b1;
          st_nxt = B_IDLE;
          if (cur_r.kind == K_CLEAR) begin
            e_st = ST_CLEARED;
          end else begin
            e_pv  = 1'b1;
            e_pt  = pt_q;
            e_rng = sq_res_r[15:0];
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_CLR;
      init_r <= 1'b1;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_CLR) begin
        cnt_r <= cnt_r + AW'(1);
        if (cnt_r == AW'(DEPTH - 1)) init_r <= 1'b0;
      end else begin
        cnt_r <= '0;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
    if (emit) begin
      ost_r  <= e_st;
      opv_r  <= e_pv;
      opt_r  <= e_pt;
      orng_r <= e_rng;
    end
    if (sq_load) begin
      sq_n_r   <= rs_q;
      sq_res_r <= '0;
      sq_bit_r <= 32'h4000_0000;
    end else if (st_r == B_SQRT && sq_bit_r != 32'd0) begin
      if (sq_n_r >= sq_sum) begin
        sq_n_r   <= sq_n_r - sq_sum;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[wr_addr] <= mark_wd;
    if (rd_en) mk_q <= mark_mem[head.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      pt_mem[wr_addr] <= cur_r.point;
      rs_mem[wr_addr] <= cur_r.rsq;
    end
    if (rd_en) begin
      pt_q <= pt_mem[head.addr[AW-1:0]];
      rs_q <= rs_mem[head.addr[AW-1:0]];
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.pixel_valid = opv_r;
  assign out_ch.out_x       = opt_r[15:0];
  assign out_ch.out_y       = opt_r[31:16];
  assign out_ch.out_z       = opt_r[47:32];
  assign out_ch.range_mm    = orng_r;

endmodule

// ===== src/point_projection_depth_buffer_unit.sv =====
// Point projection depth buffer: keeps the closest point per range image pixel.
// Depends on pdb_pkg, pdb_in_if, pdb_out_if, pdb_front, pdb_queue, pdb_back.
//
// After reset the unit sweeps every entry of the pixel mark memory with
// in_ch.ready low; configuration writes are taken during that time.
// The front end takes each item through latch, products, reciprocal
// divide by the subsample factor, classification and pixel address, and
// accepts no new item until it has pushed the current one into a two-entry
// queue that decouples it from the back end; the push waits while it is full.
// In the back end a rejected point goes straight to the result, an insert
// does a memory read, then compare and write, a pixel read does a read, a
// check, a sixteen-step square root, a finishing step, then the result,
// and a clear sweeps the mark memory one pixel per cycle. Results leave
// through a registered output so the next item can proceed while one waits.
module point_projection_depth_buffer_unit #(
  parameter int SENSOR_COLS = 128,
  parameter int SENSOR_ROWS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  pdb_in_if.sink      in_ch,
  pdb_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import pdb_pkg::*;

  cfg_t  cfg_r;
  work_t q_in, q_head;
  logic  push, pop, q_full, q_empty, init_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= 2'd0;
      cfg_r.rmin     <= 16'd100;
      cfg_r.rmax     <= 16'd10000;
      cfg_r.normal   <= 48'h4000_0000_0000;
      cfg_r.offset   <= 16'sd0;
      cfg_r.floor_mm <= 16'sh8000;
      cfg_r.ds       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   cfg_r.mode     <= cfg_data[1:0];
        CFG_RMIN:   cfg_r.rmin     <= cfg_data[15:0];
        CFG_RMAX:   cfg_r.rmax     <= cfg_data[15:0];
        CFG_NORMAL: cfg_r.normal   <= cfg_data;
        CFG_OFFSET: cfg_r.offset   <= signed'(cfg_data[15:0]);
        CFG_FLOOR:  cfg_r.floor_mm <= signed'(cfg_data[15:0]);
        CFG_SUBS:   cfg_r.ds       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  pdb_front #(.SENSOR_COLS(SENSOR_COLS), .SENSOR_ROWS(SENSOR_ROWS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .work      (q_in)
  );

  pdb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pdb_back #(.SENSOR_COLS(SENSOR_COLS), .SENSOR_ROWS(SENSOR_ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

// ===== test/tb_point_projection_depth_buffer_unit.sv =====
// Testbench for point_projection_depth_buffer_unit: directed table, then random phases
// checked against an in-bench depth buffer predictor. Depends on pdb_pkg, pdb_in_if,
// pdb_out_if and the RTL of the unit.
module tb_point_projection_depth_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pdb_pkg::*;

  localparam int COLS = 128;
  localparam int ROWS = 128;
  localparam int DEPTH = COLS * ROWS;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 272;
  localparam int STALL_LIMIT = 200000;
  localparam logic [1:0] FN_READ = 2'd1;
  localparam logic [1:0] FN_READ_ALT = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [13:0]        idx;
    logic               fin;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [6:0]         u;
    logic [6:0]         v;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         status;
    logic               pv;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        range_mm;
  } res_t;

  typedef struct packed {
    cmd_t       c;
    logic       typed;
    logic [3:0] st;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;

  pdb_in_if in_ch ();
  pdb_out_if out_ch ();

  point_projection_depth_buffer_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [1:0]         m_mode;
  logic [15:0]        m_rmin;
  logic [15:0]        m_rmax;
  logic [47:0]        m_normal;
  logic signed [15:0] m_offset;
  logic signed [15:0] m_floor;
  logic [3:0]         m_ds;
  bit                 marks [DEPTH];
  logic [47:0]        pts [DEPTH];
  logic [31:0]        sqr [DEPTH];

  res_t expected_q[$];
  logic [13:0] idx_pool[24];
  logic [6:0] hit_u[$];
  logic [6:0] hit_v[$];

  int errors = 0;
  int send_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [15:0] floor_sqrt(logic [31:0] n);
    logic [31:0] root;
    logic [31:0] bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[15:0];
  endfunction

  function automatic res_t project_point(cmd_t c);
    res_t r;
    int unsigned ds, w, h, u, v, qu, qv, pix;
    longint x, y, z, hgt, flr;
    logic [31:0] rsq, mn, mx;
    bit off;
    r = '0;
    ds = (m_ds == 0) ? 1 : m_ds;
    w = (COLS + ds - 1) / ds;
    h = (ROWS + ds - 1) / ds;
    if (c.func == FN_INSERT) begin
      x = $signed(c.x);
      y = $signed(c.y);
      z = $signed(c.z);
      rsq = 32'(x * x + y * y + z * z);
      mn = 32'(m_rmin) * 32'(m_rmin);
      mx = 32'(m_rmax) * 32'(m_rmax);
      hgt = longint'($signed(m_normal[15:0])) * x + longint'($signed(m_normal[31:16])) * y
          + longint'($signed(m_normal[47:32])) * z + longint'(m_offset) * 16384;
      flr = longint'(m_floor) * 16384;
      if (!c.fin) begin
        r.status = ST_NONFIN;
      end else if (rsq < mn || rsq > mx) begin
        r.status = ST_RANGE;
      end else if (m_mode[0] && hgt < flr) begin
        r.status = ST_GROUND;
      end else if (z <= 0) begin
        r.status = ST_BEHIND;
      end else begin
        off = 0;
        if (m_mode[1]) begin
          u = (c.idx / ROWS) / ds;
          v = (c.idx % ROWS) / ds;
        end else begin
          qu = (c.idx % COLS) / ds;
          qv = (c.idx / COLS) / ds;
          off = (qu >= w || qv >= h);
          u = w - 1 - qu;
          v = h - 1 - qv;
        end
        pix = v * w + u;
        if (off || u >= w || v >= h || pix >= DEPTH) begin
          r.status = ST_OFFGRID;
        end else if (marks[pix] && rsq >= sqr[pix]) begin
          r.status = ST_FARTHER;
        end else begin
          r.status = ST_STORED;
          marks[pix] = 1;
          sqr[pix] = rsq;
          pts[pix] = {c.z, c.y, c.x};
          hit_u.push_back(7'(u));
          hit_v.push_back(7'(v));
          if (hit_u.size() > 16) begin
            void'(hit_u.pop_front());
            void'(hit_v.pop_front());
          end
        end
      end
    end else if (c.func == FN_CLEAR) begin
      foreach (marks[k]) marks[k] = 0;
      r.status = ST_CLEARED;
    end else begin
      r.status = ST_READ;
      pix = c.v * w + c.u;
      if (c.u < w && c.v < h && pix < DEPTH && marks[pix]) begin
        r.pv = 1;
        r.x = pts[pix][15:0];
        r.y = pts[pix][31:16];
        r.z = pts[pix][47:32];
        r.range_mm = floor_sqrt(sqr[pix]);
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] index, logic [47:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    case (index)
      CFG_MODE:   m_mode = data[1:0];
      CFG_RMIN:   m_rmin = data[15:0];
      CFG_RMAX:   m_rmax = data[15:0];
      CFG_NORMAL: m_normal = data;
      CFG_OFFSET: m_offset = data[15:0];
      CFG_FLOOR:  m_floor = data[15:0];
      CFG_SUBS:   m_ds = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(cmd_t c, logic typed, logic [3:0] st);
    res_t r;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.func = c.func;
    in_ch.point_index = c.idx;
    in_ch.point_finite = c.fin;
    in_ch.coord_x = c.x;
    in_ch.coord_y = c.y;
    in_ch.coord_z = c.z;
    in_ch.pixel_u = c.u;
    in_ch.pixel_v = c.v;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    r = project_point(c);
    if (typed) begin
      r = '0;
      r.status = st;
    end
    expected_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_q.size() > 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic cmd_t random_item();
    cmd_t c;
    int lim, k;
    c.func = FN_INSERT;
    k = $urandom_range(999);
    if (k < 5) c.func = FN_CLEAR;
    else if (k < 25) c.func = FN_READ_ALT;
    else if (k < 180) c.func = FN_READ;
    c.idx = ($urandom_range(1) == 1) ? idx_pool[$urandom_range(23)] : 14'($urandom);
    c.fin = ($urandom_range(99) >= 4);
    lim = m_rmax / 2 + 1;
    if ($urandom_range(99) < 15) begin
      c.x = 16'($urandom);
      c.y = 16'($urandom);
      c.z = 16'($urandom);
    end else begin
      c.x = 16'($urandom_range(2 * lim) - lim);
      c.y = 16'($urandom_range(2 * lim) - lim);
      c.z = 16'($urandom_range(lim, 1));
      if ($urandom_range(99) < 5) c.z = -c.z;
    end
    c.u = 7'($urandom);
    c.v = 7'($urandom);
    if (hit_u.size() > 0 && $urandom_range(99) < 60) begin
      k = $urandom_range(hit_u.size() - 1);
      c.u = hit_u[k];
      c.v = hit_v[k];
    end
    return c;
  endfunction

  task automatic setup_phase(int p);
    logic [15:0] nx, ny;
    nx = 16'($urandom_range(4000) - 2000);
    ny = 16'($urandom_range(4000) - 2000);
    case (p)
      0: begin
        write_reg(CFG_MODE, 0);  write_reg(CFG_RMIN, 0);  write_reg(CFG_RMAX, 16'hFFFF);
        write_reg(CFG_NORMAL, 48'h4000_0000_0000);
        write_reg(CFG_OFFSET, 0);  write_reg(CFG_FLOOR, 16'h8000);  write_reg(CFG_SUBS, 1);
      end
      1: begin
        write_reg(CFG_MODE, 1);  write_reg(CFG_RMIN, 50);  write_reg(CFG_RMAX, 12000);
        write_reg(CFG_NORMAL, {16'h4000, ny, nx});
        write_reg(CFG_OFFSET, 48'($urandom_range(2000) - 1000));
        write_reg(CFG_FLOOR, 48'($urandom_range(2000) - 1000));
        write_reg(CFG_SUBS, 3);
      end
      2: begin
        write_reg(CFG_MODE, 2);  write_reg(CFG_RMIN, $urandom_range(300));
        write_reg(CFG_RMAX, 9000);  write_reg(CFG_NORMAL, {$urandom, $urandom});
        write_reg(CFG_OFFSET, 16'h8000);  write_reg(CFG_FLOOR, 16'h7FFF);
        write_reg(CFG_SUBS, 8);
      end
      3: begin
        write_reg(CFG_MODE, 3);  write_reg(CFG_RMIN, 100);  write_reg(CFG_RMAX, 10000);
        write_reg(CFG_NORMAL, {16'h3000, nx, ny});
        write_reg(CFG_OFFSET, 48'($urandom_range(1000)));
        write_reg(CFG_FLOOR, 48'($urandom_range(3000) - 1500));
        write_reg(CFG_SUBS, 0);
      end
      4: begin
        write_reg(CFG_MODE, $urandom_range(3));  write_reg(CFG_RMIN, $urandom_range(200));
        write_reg(CFG_RMAX, $urandom_range(65535, 5000));
        write_reg(CFG_NORMAL, {$urandom, $urandom});
        write_reg(CFG_OFFSET, $urandom);  write_reg(CFG_FLOOR, $urandom);
        write_reg(CFG_SUBS, $urandom_range(15));
      end
      default: begin
        write_reg(CFG_MODE, 1);  write_reg(CFG_RMIN, 0);  write_reg(CFG_RMAX, 40000);
        write_reg(CFG_NORMAL, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_OFFSET, 16'h7FFF);  write_reg(CFG_FLOOR, 16'h8000);
        write_reg(CFG_SUBS, 15);
      end
    endcase
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item, status %0d", out_ch.status);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status || out_ch.pixel_valid !== want.pv ||
            out_ch.out_x !== want.x || out_ch.out_y !== want.y ||
            out_ch.out_z !== want.z || out_ch.range_mm !== want.range_mm) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d",
                     want.status, want.pv, want.x, want.y, want.z, want.range_mm,
                     out_ch.status, out_ch.pixel_valid, out_ch.out_x, out_ch.out_y,
                     out_ch.out_z, out_ch.range_mm);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_point_projection_depth_buffer_unit: FAIL");
        $finish;
      end
    end
  end

  row_t dir_tab[15] = '{
    '{'{FN_READ, 14'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, 7'd0, 7'd0}, 1'b1, ST_READ},
    '{'{FN_INSERT, 14'd5, 1'b0, 16'sd300, 16'sd0, 16'sd400, 7'd0, 7'd0}, 1'b1, ST_NONFIN},
    '{'{FN_INSERT, 14'd5, 1'b1, 16'sd0, 16'sd0, 16'sd50, 7'd0, 7'd0}, 1'b1, ST_RANGE},
    '{'{FN_INSERT, 14'd5, 1'b1, 16'sd0, 16'sd0, -16'sd500, 7'd0, 7'd0}, 1'b1, ST_BEHIND},
    '{'{FN_INSERT, 14'd5, 1'b1, 16'sd32767, -16'sd32768, 16'sd32767, 7'd0, 7'd0},
      1'b1, ST_RANGE},
    '{'{FN_INSERT, 14'd0, 1'b1, 16'sd3, 16'sd4, 16'sd1000, 7'd0, 7'd0}, 1'b0, ST_STORED},
    '{'{FN_INSERT, 14'd0, 1'b1, 16'sd4, 16'sd3, 16'sd1000, 7'd0, 7'd0}, 1'b0, ST_STORED},
    '{'{FN_INSERT, 14'd0, 1'b1, 16'sd0, 16'sd0, 16'sd900, 7'd0, 7'd0}, 1'b0, ST_STORED},
    '{'{FN_READ, 14'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, 7'd127, 7'd127}, 1'b0, ST_READ},
    '{'{FN_INSERT, 14'd16383, 1'b1, -16'sd7000, 16'sd7000, 16'sd100, 7'd0, 7'd0},
      1'b0, ST_STORED},
    '{'{FN_READ, 14'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, 7'd0, 7'd0}, 1'b0, ST_READ},
    '{'{FN_READ_ALT, 14'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, 7'd0, 7'd0}, 1'b0, ST_READ},
    '{'{FN_INSERT, 14'd9, 1'b1, 16'sd1000, 16'sd0, 16'sd0, 7'd0, 7'd0}, 1'b1, ST_BEHIND},
    '{'{FN_CLEAR, 14'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 7'd0, 7'd0}, 1'b1, ST_CLEARED},
    '{'{FN_READ, 14'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, 7'd127, 7'd127}, 1'b1, ST_READ}
  };

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_INSERT;
    in_ch.point_index = '0;
    in_ch.point_finite = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.pixel_u = '0;
    in_ch.pixel_v = '0;
    out_ch.ready = 1'b0;
    m_mode = 0;
    m_rmin = 100;
    m_rmax = 10000;
    m_normal = 48'h4000_0000_0000;
    m_offset = 0;
    m_floor = 16'sh8000;
    m_ds = 1;
    foreach (marks[k]) marks[k] = 0;
    foreach (idx_pool[k]) idx_pool[k] = 14'($urandom);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k]) send_item(dir_tab[k].c, dir_tab[k].typed, dir_tab[k].st);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      setup_phase(p);
      send_idle = (p < 2) ? 9 : (p < 4) ? 85 : 0;
      rcv_idle = (p < 2) ? 85 : (p < 4) ? 9 : 0;
      if (p == 4) hold_left = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, ST_STORED);
    end

    in_ch.valid = 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_point_projection_depth_buffer_unit: PASS");
    end else begin
      $display("tb_point_projection_depth_buffer_unit: FAIL");
    end
    $finish;
  end

endmodule
